### design/two_axis_tracking_pid_offset_unit_assert.svh
// Assertion macros for the tracking PID offset unit checker.
// Bodies use the clk and rst_n names of the module that expands them.
`ifndef TWO_AXIS_TRACKING_PID_OFFSET_UNIT_ASSERT_SVH
`define TWO_AXIS_TRACKING_PID_OFFSET_UNIT_ASSERT_SVH

// same-cycle implication
`define TAPO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAPO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tapo_pkg.sv
// Shared widths, register indexes, constants and state type for the
// two-axis tracking PID offset unit. No dependencies.
`default_nettype none

package tapo_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 48;
  localparam int InUserW  = 2;
  localparam int OffW     = 48;
  localparam int OutDataW = 2 * OffW;

  localparam int GainW  = 16;
  localparam int PixW   = 16;
  localparam int ErrW   = PixW + 1;
  localparam int IntegW = 8;
  localparam int DiffW  = ErrW + 1;
  localparam int ProdW  = DiffW + GainW + 1;
  localparam int PidW   = ProdW + 1;
  localparam int SmW    = 40;

  // divide-by-5 unit, radix 4: one quotient digit per cycle
  localparam int DivW       = 44;
  localparam int DivSteps   = DivW / 2;
  localparam int DivBiasExp = 41;
  localparam int CntW       = 5;
  localparam int MulLast    = 3;

  localparam logic [CfgAddrW-1:0] REG_KP_BASE = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_KI_BASE = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_KD_BASE = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_KP_NEAR = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_KD_NEAR = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_KP_FAR  = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_KI_FAR  = 3'd6;

  localparam logic [GainW-1:0] KP_BASE_RST = 16'd26214;
  localparam logic [GainW-1:0] KI_BASE_RST = 16'd0;
  localparam logic [GainW-1:0] KD_BASE_RST = 16'd3932;
  localparam logic [GainW-1:0] KP_NEAR_RST = 16'd6554;
  localparam logic [GainW-1:0] KD_NEAR_RST = 16'd2621;
  localparam logic [GainW-1:0] KP_FAR_RST  = 16'd14418;
  localparam logic [GainW-1:0] KI_FAR_RST  = 16'd524;

  localparam logic signed [ErrW-1:0] CENTRE_X = 17'sd80;
  localparam logic signed [ErrW-1:0] CENTRE_Y = 17'sd60;
  localparam logic [PixW-1:0] AREA_NEAR = 16'd5000;
  localparam logic [PixW-1:0] AREA_FAR  = 16'd500;
  localparam int IntegLimit = 100;

  // bias keeps the dividend non-negative; quotient comes back offset by 2^DivBiasExp
  localparam logic signed [DivW:0] DIV_BIAS   = $signed((DivW + 1)'(5) << DivBiasExp);
  localparam logic signed [DivW:0] DIV_OFFSET = $signed((DivW + 1)'(1) << DivBiasExp);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOAD = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_PREP = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### design/two_axis_tracking_pid_offset_unit.sv
// Measurement, per axis in turn: error/integral load, multiply steps, two radix-4
// divide-by-5 passes (filter, then step), accumulate; out_tvalid is raised from ST_DONE.
// The divider is shared by both axes; the next request is taken only in ST_IDLE.
// Lost target or zero-point request: result handed over through ST_DONE, skipping the loop.
// rst_n (synchronous) restores gain registers and clears all loop state and offsets.
`default_nettype none

module two_axis_tracking_pid_offset_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tapo_pkg::InDataW-1:0]  in_tdata,   // target_x, target_y, target_area
  input  logic [tapo_pkg::InUserW-1:0]  in_tuser,   // operation, detected
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tapo_pkg::OutDataW-1:0] out_tdata,  // offset_x, offset_y
  input  logic                          cfg_wr_en,
  input  logic [tapo_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [tapo_pkg::CfgDataW-1:0] cfg_wdata
);
  import tapo_pkg::*;

  localparam logic signed [DiffW-1:0] ISUM_MAX = DiffW'(IntegLimit);
  localparam logic signed [DiffW-1:0] ISUM_MIN = -ISUM_MAX;
  localparam logic signed [OffW-1:0]  ACC_MAX  = {1'b0, {(OffW - 1){1'b1}}};
  localparam logic signed [OffW-1:0]  ACC_MIN  = {1'b1, {(OffW - 1){1'b0}}};

  state_t state_r;
  logic   axis_r, pass_r;
  logic [CntW-1:0] cnt_r;

  logic [GainW-1:0] kp_base_r, ki_base_r, kd_base_r, kp_near_r, kd_near_r, kp_far_r, ki_far_r;

  logic signed [IntegW-1:0] integ_x_r, integ_y_r;
  logic signed [ErrW-1:0]   last_x_r, last_y_r;
  logic signed [SmW-1:0]    sm_x_r, sm_y_r;
  logic signed [OffW-1:0]   acc_x_r, acc_y_r;

  logic [PixW-1:0] tx_r, ty_r;
  logic            near_r, far_r;

  logic signed [ErrW-1:0]   e_r;
  logic signed [IntegW-1:0] i_r;
  logic signed [DiffW-1:0]  d_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [PidW-1:0]   p_r;
  logic        [DivW-1:0]   div_r;
  logic        [2:0]        rem_r;
  logic signed [SmW-1:0]    step_r;

  logic                    out_tvalid_r;
  logic [OutDataW-1:0]     out_data_r;

  // per-axis selection
  logic [PixW-1:0]          tgt;
  logic signed [ErrW-1:0]   centre, last_cur, err_c;
  logic signed [IntegW-1:0] integ_cur, integ_nxt;
  logic signed [DiffW-1:0]  isum, diff;
  logic signed [SmW-1:0]    sm_cur;
  logic signed [OffW-1:0]   acc_cur, acc_nxt;
  logic signed [OffW:0]     acc_sum;

  // multiplier
  logic [GainW-1:0]         kp_g, ki_g, kd_g, mul_b;
  logic signed [DiffW-1:0]  mul_a;
  logic signed [ProdW-1:0]  prod;

  // divider
  logic signed [DivW:0] sm_ext, p_ext, sm5, num_filt, num_step, quot_s;
  logic [4:0]           dig_t;
  logic [1:0]           qd;
  logic [2:0]           rem_nxt;
  logic [DivW-1:0]      div_nxt;

  logic in_accept;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    tgt       = axis_r ? ty_r : tx_r;
    centre    = axis_r ? CENTRE_Y : CENTRE_X;
    integ_cur = axis_r ? integ_y_r : integ_x_r;
    last_cur  = axis_r ? last_y_r : last_x_r;
    sm_cur    = axis_r ? sm_y_r : sm_x_r;
    acc_cur   = axis_r ? acc_y_r : acc_x_r;

    err_c = centre - $signed({tgt[PixW-1], tgt});
    isum  = DiffW'(integ_cur) + DiffW'(err_c);
    diff  = DiffW'(err_c) - DiffW'(last_cur);
    if (isum > ISUM_MAX) begin
      integ_nxt = IntegW'(ISUM_MAX);
    end else if (isum < ISUM_MIN) begin
      integ_nxt = IntegW'(ISUM_MIN);
    end else begin
      integ_nxt = isum[IntegW-1:0];
    end
  end

  // gain schedule by area class latched at accept
  always_comb begin
    kp_g = near_r ? kp_near_r : (far_r ? kp_far_r : kp_base_r);
    ki_g = far_r ? ki_far_r : ki_base_r;
    kd_g = near_r ? kd_near_r : kd_base_r;
    case (cnt_r[1:0])
      2'd0: begin
        mul_a = DiffW'(e_r);
        mul_b = kp_g;
      end
      2'd1: begin
        mul_a = DiffW'(i_r);
        mul_b = ki_g;
      end
      default: begin
        mul_a = d_r;
        mul_b = kd_g;
      end
    endcase
    prod = mul_a * $signed({1'b0, mul_b});
  end

  // dividends: filter (2s + 3p + 2) and step (floor((s + 5) / 2)), both biased
  always_comb begin
    sm_ext   = (DivW + 1)'(sm_cur);
    p_ext    = (DivW + 1)'(p_r);
    num_filt = (sm_ext <<< 1) + p_ext + (p_ext <<< 1) + (DivW + 1)'(2) + DIV_BIAS;
    sm5      = sm_ext + (DivW + 1)'(5);
    num_step = (sm5 >>> 1) + DIV_BIAS;
  end

  // one radix-4 long-division digit per cycle, remainder stays below 5
  always_comb begin
    dig_t = {rem_r, div_r[DivW-1 -: 2]};
    if (dig_t >= 5'd15) begin
      qd      = 2'd3;
      rem_nxt = 3'(dig_t - 5'd15);
    end else if (dig_t >= 5'd10) begin
      qd      = 2'd2;
      rem_nxt = 3'(dig_t - 5'd10);
    end else if (dig_t >= 5'd5) begin
      qd      = 2'd1;
      rem_nxt = 3'(dig_t - 5'd5);
    end else begin
      qd      = 2'd0;
      rem_nxt = dig_t[2:0];
    end
    div_nxt = {div_r[DivW-3:0], qd};
    quot_s  = $signed({1'b0, div_nxt}) - DIV_OFFSET;
  end

  always_comb begin
    if (axis_r) begin
      acc_sum = (OffW + 1)'(acc_cur) + (OffW + 1)'(step_r);
    end else begin
      acc_sum = (OffW + 1)'(acc_cur) - (OffW + 1)'(step_r);
    end
    if (acc_sum[OffW] != acc_sum[OffW-1]) begin
      acc_nxt = acc_sum[OffW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = acc_sum[OffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      axis_r       <= 1'b0;
      pass_r       <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      kp_base_r    <= KP_BASE_RST;
      ki_base_r    <= KI_BASE_RST;
      kd_base_r    <= KD_BASE_RST;
      kp_near_r    <= KP_NEAR_RST;
      kd_near_r    <= KD_NEAR_RST;
      kp_far_r     <= KP_FAR_RST;
      ki_far_r     <= KI_FAR_RST;
      integ_x_r    <= '0;
      integ_y_r    <= '0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      sm_x_r       <= '0;
      sm_y_r       <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_KP_BASE: kp_base_r <= cfg_wdata;
          REG_KI_BASE: ki_base_r <= cfg_wdata;
          REG_KD_BASE: kd_base_r <= cfg_wdata;
          REG_KP_NEAR: kp_near_r <= cfg_wdata;
          REG_KD_NEAR: kd_near_r <= cfg_wdata;
          REG_KP_FAR:  kp_far_r  <= cfg_wdata;
          REG_KI_FAR:  ki_far_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // ST_DONE drives the valid itself when it hands over a new result
      if (out_tvalid_r && out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            tx_r   <= in_tdata[PixW-1:0];
            ty_r   <= in_tdata[2*PixW-1:PixW];
            near_r <= in_tdata[3*PixW-1:2*PixW] > AREA_NEAR;
            far_r  <= in_tdata[3*PixW-1:2*PixW] < AREA_FAR;
            axis_r <= 1'b0;
            if (in_tuser[0] || !in_tuser[1]) begin
              // lost target clears the loop; zero-point request also clears offsets
              integ_x_r <= '0;
              integ_y_r <= '0;
              last_x_r  <= '0;
              last_y_r  <= '0;
              sm_x_r    <= '0;
              sm_y_r    <= '0;
              if (in_tuser[0]) begin
                acc_x_r <= '0;
                acc_y_r <= '0;
              end
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          e_r    <= err_c;
          i_r    <= integ_nxt;
          d_r    <= diff;
          p_r    <= '0;
          cnt_r  <= '0;
          pass_r <= 1'b0;
          if (axis_r) begin
            integ_y_r <= integ_nxt;
            last_y_r  <= err_c;
          end else begin
            integ_x_r <= integ_nxt;
            last_x_r  <= err_c;
          end
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= prod;
          if (cnt_r != '0) begin
            p_r <= p_r + PidW'(prod_r);
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(MulLast)) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          div_r   <= pass_r ? num_step[DivW-1:0] : num_filt[DivW-1:0];
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          div_r <= div_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CntW'(DivSteps - 1)) begin
            if (!pass_r) begin
              if (axis_r) begin
                sm_y_r <= quot_s[SmW-1:0];
              end else begin
                sm_x_r <= quot_s[SmW-1:0];
              end
              pass_r  <= 1'b1;
              state_r <= ST_PREP;
            end else begin
              step_r  <= quot_s[SmW-1:0];
              state_r <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if (axis_r) begin
            acc_y_r <= acc_nxt;
            state_r <= ST_DONE;
          end else begin
            acc_x_r <= acc_nxt;
            axis_r  <= 1'b1;
            state_r <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= {acc_y_r, acc_x_r};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/tapo_checker.sv
// Port-level checker for the tracking PID offset unit, bound to the top level.
// Depends on tapo_pkg and two_axis_tracking_pid_offset_unit_assert.svh.
`default_nettype none

`include "two_axis_tracking_pid_offset_unit_assert.svh"

module tapo_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tapo_pkg::OutDataW-1:0] out_tdata
);
  import tapo_pkg::*;

  // one request in flight: ready drops right after an accept
  `TAPO_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready held after accept")

  // idle with no request stays idle, config writes notwithstanding
  `TAPO_ASSERT_NEXT(a_idle_holds, in_tready && !in_tvalid, in_tready, "left idle without request")

  // a fresh result appears only as the block returns to idle
  `TAPO_ASSERT_NOW(a_result_at_idle, $rose(out_tvalid), in_tready, "result raised while busy")

  `TAPO_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                    "stalled result changed")

endmodule

bind two_axis_tracking_pid_offset_unit tapo_checker u_tapo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/sv/tb.sv
// Testbench for two_axis_tracking_pid_offset_unit: directed and random camera
// requests, with the offsets checked against a Q.16 model of the tracking loop.
// Depends on tapo_pkg and the unit's RTL only.
`default_nettype none

module tb;
  import tapo_pkg::*;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_ZERO    = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic              det;
    logic [15:0]       area;
  } meas_t;

  typedef struct {
    meas_t  m;
    bit     known;
    longint kx;
    longint ky;
  } dir_row_t;

  typedef struct {
    logic signed [OffW-1:0] ox;
    logic signed [OffW-1:0] oy;
  } offsets_t;

  localparam logic [CfgAddrW-1:0] REG_UNUSED = 3'd7;
  localparam longint AccMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;
  localparam int HoldCycles = 400;
  localparam int NumDir = 21;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic [InUserW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  two_axis_tracking_pid_offset_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // target_x, target_y, target_area
    .in_tuser   (in_tuser),    // operation, detected
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // offset_x, offset_y
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // tracking loop model state
  logic [GainW-1:0] gain_reg [0:6] = '{KP_BASE_RST, KI_BASE_RST, KD_BASE_RST,
                                       KP_NEAR_RST, KD_NEAR_RST, KP_FAR_RST,
                                       KI_FAR_RST};
  longint integ_x = 0, integ_y = 0;
  longint prev_err_x = 0, prev_err_y = 0;
  longint filt_x = 0, filt_y = 0;
  longint offset_x = 0, offset_y = 0;

  offsets_t offset_q[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  dir_row_t dir_rows [NumDir] = '{
    // lost target right after reset: offsets still zero
    '{'{OP_MEASURE, 16'sh8000, 16'sh7FFF, 1'b0, 16'hFFFF}, 1'b1, 0, 0},
    // zero point with a detected flag set
    '{'{OP_ZERO, 16'sh7FFF, 16'sh8000, 1'b1, 16'd1000}, 1'b1, 0, 0},
    // target dead center from a clean loop: no correction
    '{'{OP_MEASURE, 16'sd80, 16'sd60, 1'b1, 16'd1000}, 1'b1, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd1000}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd5000}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd5001}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd500}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd0}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'hFFFF}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sh8000, 16'sh8000, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sh7FFF, 16'sh7FFF, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sh7FFF, 16'sh8000, 1'b1, 16'd200}, 1'b0, 0, 0},
    // lost target keeps the offsets, clears the loop
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b0, 16'd300}, 1'b0, 0, 0},
    '{'{OP_MEASURE, -16'sd100, 16'sd200, 1'b1, 16'd300}, 1'b0, 0, 0},
    '{'{OP_ZERO, 16'sd0, 16'sd0, 1'b0, 16'd0}, 1'b1, 0, 0},
    '{'{OP_MEASURE, 16'sd160, 16'sd120, 1'b1, 16'd20000}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd0, 16'sd0, 1'b1, 16'd499}, 1'b0, 0, 0},
    '{'{OP_MEASURE, 16'sd80, 16'sd60, 1'b1, 16'd1000}, 1'b0, 0, 0}
  };

  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0)
      q = q - 1;
    return q;
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > AccMax)
      return AccMax;
    if (v < AccMin)
      return AccMin;
    return v;
  endfunction

  // one PID axis: integral clamp, Q.16 sum, 0.4/0.6 filter, 0.1 step
  function automatic longint pid_axis(input longint err, inout longint integ,
                                      inout longint prev, inout longint filt,
                                      input longint kp, input longint ki,
                                      input longint kd);
    longint acc;
    longint pid;
    acc = integ + err;
    if (acc > IntegLimit)
      acc = IntegLimit;
    if (acc < -IntegLimit)
      acc = -IntegLimit;
    integ = acc;
    pid = err * kp + acc * ki + (err - prev) * kd;
    prev = err;
    filt = floor_quot(2 * filt + 3 * pid + 2, 5);
    return floor_quot(filt + 5, 10);
  endfunction

  task automatic clear_loop();
    integ_x = 0;
    integ_y = 0;
    prev_err_x = 0;
    prev_err_y = 0;
    filt_x = 0;
    filt_y = 0;
  endtask

  task automatic track_request(input meas_t m, output offsets_t res);
    longint kp, ki, kd, dx, dy;
    if (m.op == OP_ZERO) begin
      clear_loop();
      offset_x = 0;
      offset_y = 0;
    end else if (!m.det) begin
      clear_loop();
    end else begin
      kp = gain_reg[REG_KP_BASE];
      ki = gain_reg[REG_KI_BASE];
      kd = gain_reg[REG_KD_BASE];
      if (m.area > AREA_NEAR) begin
        kp = gain_reg[REG_KP_NEAR];
        kd = gain_reg[REG_KD_NEAR];
      end else if (m.area < AREA_FAR) begin
        kp = gain_reg[REG_KP_FAR];
        ki = gain_reg[REG_KI_FAR];
      end
      dx = pid_axis(80 - longint'(m.tx), integ_x, prev_err_x, filt_x, kp, ki, kd);
      dy = pid_axis(60 - longint'(m.ty), integ_y, prev_err_y, filt_y, kp, ki, kd);
      offset_x = clamp48(offset_x - dx);
      offset_y = clamp48(offset_y + dy);
    end
    res.ox = offset_x[OffW-1:0];
    res.oy = offset_y[OffW-1:0];
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= REG_KI_FAR)
      gain_reg[idx] = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_gains(input logic [15:0] kpb, input logic [15:0] kib,
                               input logic [15:0] kdb, input logic [15:0] kpn,
                               input logic [15:0] kdn, input logic [15:0] kpf,
                               input logic [15:0] kif);
    write_reg(REG_KP_BASE, kpb);
    write_reg(REG_KI_BASE, kib);
    write_reg(REG_KD_BASE, kdb);
    write_reg(REG_KP_NEAR, kpn);
    write_reg(REG_KD_NEAR, kdn);
    write_reg(REG_KP_FAR, kpf);
    write_reg(REG_KI_FAR, kif);
  endtask

  // present one request; returns at the accepting rising edge
  task automatic send_request(input meas_t m, input bit known, input longint kx,
                              input longint ky);
    offsets_t res;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {m.area, m.ty, m.tx};
    in_tuser <= {m.det, m.op};
    do
      @(posedge clk);
    while (in_tready !== 1'b1);
    track_request(m, res);
    if (known) begin
      res.ox = kx[OffW-1:0];
      res.oy = ky[OffW-1:0];
    end
    offset_q.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (offset_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic meas_t random_request();
    meas_t m;
    int roll;
    roll = $urandom_range(99);
    m.op = OP_MEASURE;
    m.tx = 16'($urandom);
    m.ty = 16'($urandom);
    m.det = 1'b1;
    m.area = 16'($urandom);
    if (roll < 4) begin
      m.op = OP_ZERO;
      m.det = 1'($urandom_range(1));
    end else if (roll < 10) begin
      m.det = 1'b0;
    end else if (roll >= 22) begin
      // target near the image center, area picked around the gain-schedule thresholds
      m.tx = 16'(80 + int'($urandom_range(400)) - 200);
      m.ty = 16'(60 + int'($urandom_range(300)) - 150);
      case ($urandom_range(7))
        0: m.area = 16'($urandom_range(498));
        1: m.area = 16'd499;
        2: m.area = 16'd500;
        3: m.area = 16'd5000;
        4: m.area = 16'd5001;
        5: m.area = 16'($urandom_range(5000, 500));
        6: m.area = 16'($urandom_range(65535, 5001));
        default: m.area = 16'($urandom_range(200));
      endcase
    end
    return m;
  endfunction

  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int n = 0; n < count; n++) begin
      case ((n / 40) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (n == hold_at)
        holds_asked++;
      if (n == pause_at)
        wait_drained();
      send_request(random_request(), 1'b0, 0, 0);
    end
    wait_drained();
  endtask

  // result side: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HoldCycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_result
    offsets_t want;
    logic signed [OffW-1:0] got_x;
    logic signed [OffW-1:0] got_y;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got_x = out_tdata[OffW-1:0];
      got_y = out_tdata[OutDataW-1:OffW];
      if (offset_q.size() == 0) begin
        $error("result with no request pending: offset_x %0d offset_y %0d", got_x, got_y);
        mismatches++;
      end else begin
        want = offset_q.pop_front();
        if (got_x !== want.ox) begin
          $error("offset_x mismatch: expected %0d, got %0d", want.ox, got_x);
          mismatches++;
        end
        if (got_y !== want.oy) begin
          $error("offset_y mismatch: expected %0d, got %0d", want.oy, got_y);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_request(dir_rows[r].m, dir_rows[r].known, dir_rows[r].kx, dir_rows[r].ky);
    wait_drained();
    run_random(120, -1, -1);

    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_UNUSED, 16'($urandom));   // out-of-range index, must be ignored
    run_random(110, -1, -1);

    program_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(60, -1, -1);

    program_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    run_random(120, 30, -1);

    program_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    run_random(120, -1, 60);

    program_gains(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    run_random(120, 50, 90);

    repeat (120) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
